// ===== hdl/crc_checked_frame_receiver_top_assert.svh =====
// assertion macros for the frame receiver
`ifndef CRC_CHECKED_FRAME_RECEIVER_TOP_ASSERT_SVH
`define CRC_CHECKED_FRAME_RECEIVER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define CCFR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define CCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CCFR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/ccfr_pkg.sv =====
// shared constants, types and the crc byte update for the frame receiver
`default_nettype none

package ccfr_pkg;

    localparam int PAYLOAD_DEPTH = 512;
    localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);

    localparam logic [7:0]  LEGACY_LOW  = 8'h41;
    localparam logic [7:0]  LEGACY_HIGH = 8'h7A;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;

    localparam logic [2:0] EV_LEGACY  = 3'd0;
    localparam logic [2:0] EV_FRAME_OK = 3'd1;
    localparam logic [2:0] EV_CRC_ERR = 3'd2;
    localparam logic [2:0] EV_OVERFLOW = 3'd3;
    localparam logic [2:0] EV_READ    = 3'd4;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr_req;

    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic [7:0]  cmd;
        logic [15:0] len;
    } t_frame_evt;

    // reflected crc-32, one byte, lsb first
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/crc_checked_frame_receiver_top.sv =====
// Length-prefixed frame receiver with crc-32 check and payload buffer.
// Input channel (i_valid/o_ready): one word per cycle when o_ready, i_mode selects a
// received byte (0) or a read of the payload buffer at i_read_index (1).
// Output channel (o_valid/i_ready): zero or one event word per input word:
// legacy command, frame ok, crc error, overflow or read data.
// An event word appears on the outputs in the cycle after the word that
// causes it is accepted. Throughput: one input word per cycle while
// o_ready is high; the byte-wide crc update and the buffer write or
// registered buffer read each fit in that cycle.
// Bytes of a frame that cause no event leave the output register alone.
// Reset clears the parser to idle and empties the output register; the
// payload buffer keeps its contents and must be written before it is read.
// When the receiver holds i_ready low, a pending event stays put and o_ready
// stays low while it waits, whatever kind of word is offered; with the
// register free, or taken by the receiver in the same cycle, a new word is
// accepted.
`default_nettype none

`include "crc_checked_frame_receiver_top_assert.svh"

module crc_checked_frame_receiver_top
    import ccfr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_mode,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [8:0]  i_read_index,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_event_kind,
    output logic [7:0]       o_command_byte,
    output logic [15:0]      o_payload_length,
    output logic [7:0]       o_read_data
);

    logic        accept;
    logic        rd_en;
    t_wr_req     wr;
    t_frame_evt  evt;

    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        mem [PAYLOAD_DEPTH];

    logic        r_valid, n_valid;
    logic [2:0]  r_kind;
    logic [7:0]  r_cmd;
    logic [15:0] r_len;
    logic [7:0]  r_rd_q;
    logic        r_rd_oob;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign rd_en   = accept && i_mode;
    assign rd_addr = ADDR_W'(i_read_index);

    ccfr_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (accept && !i_mode),
        .i_byte  (i_rx_byte),
        .o_wr    (wr),
        .o_evt   (evt)
    );

    // payload buffer, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            r_rd_q   <= mem[rd_addr];
            r_rd_oob <= (32'(i_read_index) >= PAYLOAD_DEPTH);
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (rd_en || evt.valid) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_kind <= EV_READ;
            r_cmd  <= 8'd0;
            r_len  <= 16'd0;
        end else if (evt.valid) begin
            r_kind <= evt.kind;
            r_cmd  <= evt.cmd;
            r_len  <= evt.len;
        end
    end

    assign o_valid          = r_valid;
    assign o_event_kind     = r_kind;
    assign o_command_byte   = r_cmd;
    assign o_payload_length = r_len;
    assign o_read_data      = (r_kind == EV_READ && !r_rd_oob) ? r_rd_q : 8'd0;

    `CCFR_ASSERT_SAME(a_stall_means_full, i_clk, i_rst_n, !o_ready, r_valid)
    `CCFR_ASSERT_NEXT(a_read_reports, i_clk, i_rst_n, rd_en,
        (o_valid && o_event_kind == EV_READ))
    `CCFR_ASSERT_SAME(a_empty_frame_cmd, i_clk, i_rst_n,
        (o_valid && o_payload_length == 16'd0 && (o_event_kind == EV_FRAME_OK ||
        o_event_kind == EV_CRC_ERR || o_event_kind == EV_OVERFLOW)),
        (o_command_byte == 8'd0))

endmodule

`default_nettype wire

// ===== hdl/ccfr_parser.sv =====
// frame parser: legacy commands, length, payload with crc-32, trailing crc compare
`default_nettype none

module ccfr_parser
    import ccfr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_byte,
    output t_wr_req         o_wr,
    output t_frame_evt      o_evt
);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_LEN_LO = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;
    localparam logic [1:0] PH_CRC    = 2'd3;

    logic [1:0]  r_phase,   n_phase;
    logic [15:0] r_length,  n_length;
    logic [15:0] r_taken,   n_taken;
    logic [31:0] r_crc,     n_crc;
    logic [23:0] r_rcv,     n_rcv;
    logic [1:0]  r_crc_cnt, n_crc_cnt;
    logic        r_ovf,     n_ovf;
    logic [7:0]  r_first,   n_first;

    logic [15:0] len_full;
    logic [15:0] taken_inc;
    logic [31:0] crc_full;
    logic        fits;

    assign len_full  = {r_length[15:8], i_byte};
    assign taken_inc = r_taken + 16'd1;
    assign crc_full  = {r_rcv, i_byte};
    assign fits      = (17'(r_taken) < 17'(PAYLOAD_DEPTH));

    always_comb begin
        n_phase   = r_phase;
        n_length  = r_length;
        n_taken   = r_taken;
        n_crc     = r_crc;
        n_rcv     = r_rcv;
        n_crc_cnt = r_crc_cnt;
        n_ovf     = r_ovf;
        n_first   = r_first;
        o_wr.en   = 1'b0;
        o_wr.addr = ADDR_W'(r_taken);
        o_wr.data = i_byte;
        o_evt.valid = 1'b0;
        o_evt.kind  = EV_LEGACY;
        o_evt.cmd   = i_byte;
        o_evt.len   = 16'd0;
        if (i_take) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_byte >= LEGACY_LOW && i_byte <= LEGACY_HIGH) begin
                        o_evt.valid = 1'b1;
                    end else begin
                        n_length = {i_byte, 8'd0};
                        n_phase  = PH_LEN_LO;
                    end
                end
                PH_LEN_LO: begin
                    n_length  = len_full;
                    n_taken   = 16'd0;
                    n_crc     = CRC_INIT;
                    n_rcv     = 24'd0;
                    n_crc_cnt = 2'd0;
                    n_ovf     = 1'b0;
                    n_phase   = (len_full == 16'd0) ? PH_CRC : PH_DATA;
                end
                PH_DATA: begin
                    if (fits) begin
                        o_wr.en = 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    // byte 0 kept aside for the frame report
                    if (r_taken == 16'd0) begin
                        n_first = i_byte;
                    end
                    n_crc   = crc32_byte(r_crc, i_byte);
                    n_taken = taken_inc;
                    if (taken_inc == r_length) begin
                        n_phase   = PH_CRC;
                        n_crc_cnt = 2'd0;
                        n_rcv     = 24'd0;
                    end
                end
                PH_CRC: begin
                    n_rcv     = crc_full[23:0];
                    n_crc_cnt = r_crc_cnt + 2'd1;
                    if (r_crc_cnt == 2'd3) begin
                        n_phase     = PH_IDLE;
                        o_evt.valid = 1'b1;
                        o_evt.len   = r_length;
                        o_evt.cmd   = (r_length == 16'd0) ? 8'd0 : r_first;
                        priority if (r_ovf) begin
                            o_evt.kind = EV_OVERFLOW;
                        end else if ((r_crc ^ CRC_INIT) == crc_full) begin
                            o_evt.kind = EV_FRAME_OK;
                        end else begin
                            o_evt.kind = EV_CRC_ERR;
                        end
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_length  <= 16'd0;
            r_taken   <= 16'd0;
            r_crc     <= CRC_INIT;
            r_rcv     <= 24'd0;
            r_crc_cnt <= 2'd0;
            r_ovf     <= 1'b0;
            r_first   <= 8'd0;
        end else begin
            r_phase   <= n_phase;
            r_length  <= n_length;
            r_taken   <= n_taken;
            r_crc     <= n_crc;
            r_rcv     <= n_rcv;
            r_crc_cnt <= n_crc_cnt;
            r_ovf     <= n_ovf;
            r_first   <= n_first;
        end
    end

endmodule

`default_nettype wire
